FILE: hw/rtl/qlm_pkg.sv
// Shared types and constants for the queued lock manager.
`default_nettype none
package qlm_pkg;
  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_LOCK    = 2'd1,
    CMD_UNLOCK  = 2'd2,
    CMD_TRYLOCK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_QUEUED   = 2'd1,
    ST_NOTOWNER = 2'd2,
    ST_BUSY     = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the input transaction
    logic execute;    // apply the command to the tables
    logic walk_init;  // start the wait-for walk at the owner
    logic walk_step;  // one walk step
    logic init_sweep; // clear waiters of one process on init
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_walk;  // command queued the caller
    logic need_sweep; // command was init
    logic walk_done;  // walk finished this step
    logic sweep_done; // last process swept
  } dp_stat_t;
endpackage
`default_nettype wire

FILE: hw/rtl/qlm_if.sv
// Valid/ready channel interface carrying a payload.
`default_nettype none
interface qlm_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/queued_lock_manager_deadlock_check.sv
// Queued lock manager with wait-for deadlock check: top level.
// One command transaction in (command, lock_id, proc_id), one result out.
// Commands: init, lock, unlock, trylock on a table of NUM_LOCKS locks.
// Steps: capture, execute, then an optional wait-for walk or init sweep, then
// the result is shown. A lock that queues the caller walks the wait-for chain
// from the lock owner, one process per cycle, up to NUM_PROCS processes; init
// sweeps all NUM_PROCS processes and clears the waiters on that lock.
// One item is in flight at a time; in_ready is high only while idle.
// The result stays on out_* until out_ready takes it; a stalled receiver
// holds off the next input transaction.
// Reset (rst_n low, synchronous) frees all locks and clears all waiters.
// No configuration port.
`default_nettype none
module queued_lock_manager_deadlock_check #(
  parameter int NUM_LOCKS = 16,
  parameter int NUM_PROCS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [3:0]  in_lock_id,
  input  wire logic [3:0]  in_proc_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic             out_woken_valid,
  output logic [3:0]       out_woken_proc,
  output logic             out_deadlock_found,
  output logic [15:0]      out_deadlock_members
);
  import qlm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  qlm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  qlm_dp #(.NUM_LOCKS(NUM_LOCKS), .NUM_PROCS(NUM_PROCS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_command(in_command), .in_lock_id(in_lock_id), .in_proc_id(in_proc_id),
    .cmd(cmd), .stat(stat),
    .out_status(out_status), .out_woken_valid(out_woken_valid),
    .out_woken_proc(out_woken_proc), .out_deadlock_found(out_deadlock_found),
    .out_deadlock_members(out_deadlock_members)
  );
endmodule
`default_nettype wire

FILE: hw/rtl/qlm_ctrl.sv
// Controller state machine for the lock manager.
`default_nettype none
module qlm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output qlm_pkg::dp_cmd_t       cmd,
  input  wire qlm_pkg::dp_stat_t stat
);
  import qlm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_WALK, S_SWEEP, S_OUT} state_t;
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        if (stat.need_walk) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end else if (stat.need_sweep) begin
          state_nxt = S_SWEEP;
        end else begin
          state_nxt     = S_OUT;
          out_valid_nxt = 1'b1;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_done) begin
          state_nxt     = S_OUT;
          out_valid_nxt = 1'b1;
        end
      end
      S_SWEEP: begin
        cmd.init_sweep = 1'b1;
        if (stat.sweep_done) begin
          state_nxt     = S_OUT;
          out_valid_nxt = 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/qlm_dp.sv
// Datapath: lock tables, wait queues, wait-for walk and result register.
`default_nettype none
module qlm_dp #(
  parameter int NUM_LOCKS = 16,
  parameter int NUM_PROCS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       in_command,
  input  wire logic [3:0]       in_lock_id,
  input  wire logic [3:0]       in_proc_id,
  input  wire qlm_pkg::dp_cmd_t cmd,
  output qlm_pkg::dp_stat_t     stat,
  output logic [1:0]            out_status,
  output logic                  out_woken_valid,
  output logic [3:0]            out_woken_proc,
  output logic                  out_deadlock_found,
  output logic [15:0]           out_deadlock_members
);
  import qlm_pkg::*;

  localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int PW = $clog2(NUM_PROCS);

  // tables
  logic [NUM_LOCKS-1:0] held_r, qne_r;
  logic [3:0]           owner_r [NUM_LOCKS];
  logic [3:0]           qhead_r [NUM_LOCKS];
  logic [3:0]           qtail_r [NUM_LOCKS];
  logic [NUM_PROCS-1:0] waiting_r;
  logic [3:0]           nextw_r [NUM_PROCS];
  logic [3:0]           wlock_r [NUM_PROCS];

  // captured transaction
  logic [1:0] c_cmd_r;
  logic [3:0] c_lk_r, c_pr_r;

  // walk state
  logic [3:0]  start_r, wp_r;
  logic [15:0] mem_r;
  logic [PW:0] step_r;
  logic [PW:0] sweep_r;

  // result register
  logic [1:0]  status_r;
  logic        wv_r, df_r;
  logic [3:0]  wproc_r;
  logic [15:0] dm_r;

  logic            lk_ok, pr_ok, wl_ok, wp_ok;
  logic [LW-1:0]   lk;
  logic [PW-1:0]   pr, wpi, swi;
  logic [3:0]      head;
  logic            head_ok, cur_ok;
  logic [LW-1:0]   wl;
  logic [3:0]      wl_raw;

  assign lk_ok  = ({28'd0, c_lk_r} < NUM_LOCKS);
  assign pr_ok  = ({28'd0, c_pr_r} < NUM_PROCS);
  assign lk     = c_lk_r[LW-1:0];
  assign pr     = c_pr_r[PW-1:0];
  assign head   = qhead_r[lk];
  assign head_ok = ({28'd0, head} < NUM_PROCS);
  assign wp_ok  = ({28'd0, wp_r} < NUM_PROCS);
  assign wpi    = wp_r[PW-1:0];
  assign wl_raw = wlock_r[wpi];
  assign wl_ok  = ({28'd0, wl_raw} < NUM_LOCKS);
  assign wl     = wl_raw[LW-1:0];
  assign swi    = sweep_r[PW-1:0];
  assign cur_ok = wp_ok && waiting_r[wpi] && wl_ok && held_r[wl];

  // status to controller
  always_comb begin
    stat.need_walk  = lk_ok && pr_ok && c_cmd_r == CMD_LOCK && !waiting_r[pr]
                      && held_r[lk];
    stat.need_sweep = lk_ok && pr_ok && c_cmd_r == CMD_INIT;
    stat.walk_done  = !cur_ok || owner_r[wl] == start_r
                      || step_r == (PW+1)'(NUM_PROCS - 1);
    stat.sweep_done = (sweep_r == (PW+1)'(NUM_PROCS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      qne_r     <= '0;
      waiting_r <= '0;
      for (int i = 0; i < NUM_LOCKS; i++) owner_r[i] <= '0;
    end else begin
      if (cmd.capture) begin
        c_cmd_r <= in_command;
        c_lk_r  <= in_lock_id;
        c_pr_r  <= in_proc_id;
      end
      // apply command
      if (cmd.execute) begin
        status_r <= ST_OK;
        wv_r     <= 1'b0;
        wproc_r  <= '0;
        df_r     <= 1'b0;
        dm_r     <= '0;
        sweep_r  <= '0;
        if (!lk_ok || !pr_ok) begin
          status_r <= ST_BUSY;
        end else if (c_cmd_r == CMD_INIT) begin
          held_r[lk]  <= 1'b0;
          owner_r[lk] <= '0;
          qne_r[lk]   <= 1'b0;
        end else if (c_cmd_r == CMD_UNLOCK) begin
          if (!held_r[lk] || owner_r[lk] != c_pr_r) begin
            status_r <= ST_NOTOWNER;
          end else if (!qne_r[lk]) begin
            held_r[lk]  <= 1'b0;
            owner_r[lk] <= '0;
          end else begin
            owner_r[lk] <= head;
            if (head_ok) waiting_r[head[PW-1:0]] <= 1'b0;
            if (head == qtail_r[lk] || !head_ok) qne_r[lk] <= 1'b0;
            else qhead_r[lk] <= nextw_r[head[PW-1:0]];
            wv_r    <= 1'b1;
            wproc_r <= head;
          end
        end else if (waiting_r[pr]) begin
          status_r <= ST_BUSY;
        end else if (!held_r[lk]) begin
          held_r[lk]  <= 1'b1;
          owner_r[lk] <= c_pr_r;
        end else if (c_cmd_r == CMD_TRYLOCK) begin
          status_r <= ST_BUSY;
        end else begin
          waiting_r[pr] <= 1'b1;
          wlock_r[pr]   <= c_lk_r;
          if (!qne_r[lk]) begin
            qhead_r[lk] <= c_pr_r;
            qne_r[lk]   <= 1'b1;
          end else if ({28'd0, qtail_r[lk]} < NUM_PROCS) begin
            nextw_r[qtail_r[lk][PW-1:0]] <= c_pr_r;
          end
          qtail_r[lk] <= c_pr_r;
          status_r    <= ST_QUEUED;
        end
      end
      // start walk
      if (cmd.walk_init) begin
        start_r <= owner_r[lk];
        wp_r    <= owner_r[lk];
        mem_r   <= '0;
        step_r  <= '0;
      end
      // one walk step per cycle
      if (cmd.walk_step) begin
        if (cur_ok && owner_r[wl] == start_r) begin
          df_r <= 1'b1;
          dm_r <= mem_r | (16'd1 << wp_r);
        end
        mem_r  <= mem_r | (16'd1 << wp_r);
        wp_r   <= owner_r[wl];
        step_r <= step_r + 1'b1;
      end
      // init: release waiters one process a cycle
      if (cmd.init_sweep) begin
        if (waiting_r[swi] && wlock_r[swi] == c_lk_r) waiting_r[swi] <= 1'b0;
        sweep_r <= sweep_r + 1'b1;
      end
    end
  end

  assign out_status           = status_r;
  assign out_woken_valid      = wv_r;
  assign out_woken_proc       = wproc_r;
  assign out_deadlock_found   = df_r;
  assign out_deadlock_members = dm_r;
endmodule
`default_nettype wire

FILE: tb/sv/qlm_tb_pkg.sv
// Transaction types for the lock manager testbench channels.
package qlm_tb_pkg;
  import qlm_pkg::*;

  typedef struct packed {
    cmd_t       command;
    logic [3:0] lock_id;
    logic [3:0] proc_id;
  } lock_cmd_t;

  typedef struct packed {
    status_t     status;
    logic        woken_valid;
    logic [3:0]  woken_proc;
    logic        deadlock_found;
    logic [15:0] deadlock_members;
  } lock_result_t;
endpackage

FILE: tb/sv/qlm_lock_checker.sv
// Passive checker: tracks lock table state and compares every result transaction.
module qlm_lock_checker
  import qlm_pkg::*;
  import qlm_tb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cmd_valid,
  input  logic         cmd_ready,
  input  lock_cmd_t    cmd,
  input  logic         res_valid,
  input  logic         res_ready,
  input  lock_result_t res,
  output int           pending,
  output int           fail_count
);
  localparam int NLOCK = 16;
  localparam int NPROC = 16;

  // Shadow lock table
  logic       held     [NLOCK];
  logic [3:0] owner    [NLOCK];
  logic       q_busy   [NLOCK];
  logic [3:0] q_head   [NLOCK];
  logic [3:0] q_tail   [NLOCK];
  logic [3:0] next_wt  [NPROC];
  logic       waiting  [NPROC];
  logic [3:0] waits_on [NPROC];

  lock_result_t expected_results[$];

  // Follow the wait-for chain from the owner of lk
  function automatic logic [16:0] deadlock_walk(logic [3:0] lk);
    logic [3:0]  start;
    logic [3:0]  p;
    logic [3:0]  wl;
    logic [15:0] members;
    start   = owner[lk];
    p       = start;
    members = '0;
    for (int s = 0; s < NPROC; s++) begin
      members[p] = 1'b1;
      if (!waiting[p]) return '0;
      wl = waits_on[p];
      if (!held[wl]) return '0;
      if (owner[wl] == start) return {1'b1, members};
      p = owner[wl];
    end
    return '0;
  endfunction

  // Apply one command to the shadow table and return its result
  function automatic lock_result_t apply_command(lock_cmd_t c);
    lock_result_t r;
    logic [3:0]   lk;
    logic [3:0]   pr;
    logic [3:0]   w;
    logic [16:0]  walk;
    r  = '0;
    r.status = ST_OK;
    lk = c.lock_id;
    pr = c.proc_id;
    case (c.command)
      CMD_INIT: begin
        held[lk]   = 1'b0;
        owner[lk]  = '0;
        q_busy[lk] = 1'b0;
        for (int i = 0; i < NPROC; i++)
          if (waiting[i] && waits_on[i] == lk) waiting[i] = 1'b0;
      end
      CMD_UNLOCK: begin
        if (!held[lk] || owner[lk] != pr) begin
          r.status = ST_NOTOWNER;
        end else if (!q_busy[lk]) begin
          held[lk]  = 1'b0;
          owner[lk] = '0;
        end else begin
          w = q_head[lk];
          owner[lk]  = w;
          waiting[w] = 1'b0;
          if (w == q_tail[lk]) q_busy[lk] = 1'b0;
          else q_head[lk] = next_wt[w];
          r.woken_valid = 1'b1;
          r.woken_proc  = w;
        end
      end
      default: begin
        if (waiting[pr]) begin
          r.status = ST_BUSY;
        end else if (!held[lk]) begin
          held[lk]  = 1'b1;
          owner[lk] = pr;
        end else if (c.command == CMD_TRYLOCK) begin
          r.status = ST_BUSY;
        end else begin
          waiting[pr]  = 1'b1;
          waits_on[pr] = lk;
          if (!q_busy[lk]) begin
            q_head[lk] = pr;
            q_busy[lk] = 1'b1;
          end else begin
            next_wt[q_tail[lk]] = pr;
          end
          q_tail[lk] = pr;
          walk = deadlock_walk(lk);
          r.deadlock_found   = walk[16];
          r.deadlock_members = walk[15:0];
          r.status = ST_QUEUED;
        end
      end
    endcase
    return r;
  endfunction

  assign pending = expected_results.size();

  // Predict on accepted commands, compare on accepted results
  always @(posedge clk) begin
    lock_result_t e;
    if (!rst_n) begin
      for (int i = 0; i < NLOCK; i++) begin
        held[i] = 0; owner[i] = 0; q_busy[i] = 0; q_head[i] = 0; q_tail[i] = 0;
      end
      for (int i = 0; i < NPROC; i++) begin
        next_wt[i] = 0; waiting[i] = 0; waits_on[i] = 0;
      end
      expected_results.delete();
    end else begin
      if (cmd_valid && cmd_ready) expected_results.push_back(apply_command(cmd));
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: %p", res);
          fail_count = fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (res.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, res.status);
            fail_count = fail_count + 1;
          end
          if (res.woken_valid !== e.woken_valid) begin
            $error("woken_valid: expected %0d actual %0d", e.woken_valid, res.woken_valid);
            fail_count = fail_count + 1;
          end
          if (res.woken_proc !== e.woken_proc) begin
            $error("woken_proc: expected %0d actual %0d", e.woken_proc, res.woken_proc);
            fail_count = fail_count + 1;
          end
          if (res.deadlock_found !== e.deadlock_found) begin
            $error("deadlock_found: expected %0d actual %0d",
                   e.deadlock_found, res.deadlock_found);
            fail_count = fail_count + 1;
          end
          if (res.deadlock_members !== e.deadlock_members) begin
            $error("deadlock_members: expected %h actual %h",
                   e.deadlock_members, res.deadlock_members);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

  initial fail_count = 0;
endmodule

FILE: tb/sv/tb_queued_lock_manager_deadlock_check.sv
// Testbench top: clock, reset, command stimulus, result backpressure and verdict.
module tb_queued_lock_manager_deadlock_check;
  import qlm_pkg::*;
  import qlm_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   pending;
  int   fail_count;

  qlm_if #(.payload_t(lock_cmd_t))    cmd_ch (clk);
  qlm_if #(.payload_t(lock_result_t)) res_ch (clk);

  always #2 clk = ~clk;

  queued_lock_manager_deadlock_check dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (cmd_ch.valid),
    .in_ready             (cmd_ch.ready),
    .in_command           (cmd_ch.data.command),
    .in_lock_id           (cmd_ch.data.lock_id),
    .in_proc_id           (cmd_ch.data.proc_id),
    .out_valid            (res_ch.valid),
    .out_ready            (res_ch.ready),
    .out_status           (res_ch.data.status),
    .out_woken_valid      (res_ch.data.woken_valid),
    .out_woken_proc       (res_ch.data.woken_proc),
    .out_deadlock_found   (res_ch.data.deadlock_found),
    .out_deadlock_members (res_ch.data.deadlock_members)
  );

  qlm_lock_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_ch.valid),
    .cmd_ready  (cmd_ch.ready),
    .cmd        (cmd_ch.data),
    .res_valid  (res_ch.valid),
    .res_ready  (res_ch.ready),
    .res        (res_ch.data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // Receiver backpressure
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one command transaction, with optional idle cycles first
  task automatic send_cmd(cmd_t c, int lk, int pr);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.data.command <= c;
    cmd_ch.data.lock_id <= 4'(lk);
    cmd_ch.data.proc_id <= 4'(pr);
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Random command, mostly on a few locks and processes so chains form
  task automatic send_random;
    int   r;
    int   lk;
    int   pr;
    cmd_t c;
    r = $urandom_range(99);
    c = (r < 5) ? CMD_INIT : (r < 45) ? CMD_LOCK : (r < 80) ? CMD_UNLOCK : CMD_TRYLOCK;
    if ($urandom_range(99) < 70) begin
      lk = $urandom_range(3);
      pr = $urandom_range(3);
    end else begin
      lk = $urandom_range(15);
      pr = $urandom_range(15);
    end
    send_cmd(c, lk, pr);
  endtask

  initial begin
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.data    <= '0;
    res_ch.ready   <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: acquire, self-deadlock, handoff, two-process cycle, init, errors
    send_cmd(CMD_INIT,    0, 0);
    send_cmd(CMD_LOCK,    0, 0);
    send_cmd(CMD_LOCK,    0, 0);
    send_cmd(CMD_UNLOCK,  0, 1);
    send_cmd(CMD_UNLOCK,  0, 0);
    send_cmd(CMD_TRYLOCK, 0, 1);
    send_cmd(CMD_LOCK,    1, 1);
    send_cmd(CMD_LOCK,    0, 1);
    send_cmd(CMD_LOCK,    1, 0);
    send_cmd(CMD_LOCK,    5, 1);
    send_cmd(CMD_TRYLOCK, 5, 1);
    send_cmd(CMD_INIT,    0, 9);
    send_cmd(CMD_UNLOCK,  1, 1);
    send_cmd(CMD_UNLOCK,  7, 3);
    send_cmd(CMD_TRYLOCK, 15, 15);
    send_cmd(CMD_LOCK,    15, 14);
    send_cmd(CMD_LOCK,    14, 15);
    send_cmd(CMD_UNLOCK,  15, 15);
    send_cmd(CMD_UNLOCK,  15, 14);
    send_cmd(CMD_UNLOCK,  15, 14);
    send_cmd(CMD_INIT,    15, 15);

    // Hold off until the block has drained
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);

    // Random phases with different idle and stall mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      repeat (116) send_random();
    end
    cmd_ch.valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
